[design/cfla_pkg.sv]
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared codes and defaults for the cursor free-list allocator.
// ----------------------------------------------------------------------------
package cfla_pkg;

   localparam int NODE_COUNT_DEF = 16;

   // command codes
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;
   localparam logic [1:0] CMD_DUMP   = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

endpackage

[design/cursor_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// cursor_free_list_allocator
// Node pool with a free list and one linked list kept in a link memory.
// ----------------------------------------------------------------------------
// After reset the block runs an init pass that chains the link memory; busy
// stays high during it. A command is taken when start is high and busy is low.
// Free, and allocate/insert with an empty pool, and dump of an empty list
// answer in the cycle after the command and leave busy low. Allocate and insert
// read the link of the free head from the link memory, which becomes the new
// free head; insert also writes the popped node's link and byte to put it at
// the list head. Dump gives one result beat per node, one per cycle, after the
// first read: each step waits on the link read of the node before it. Results
// come as single-cycle beats on rsp_valid; the receiver cannot stall them.
module cursor_free_list_allocator #(
   parameter int NODE_COUNT = cfla_pkg::NODE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_node_index,
   input  logic [7:0] req_elem_byte,
   output logic       rsp_valid,
   output logic [3:0] rsp_out_index,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int LW = $clog2(NODE_COUNT + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);
   localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] init_cnt_ff, init_cnt_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [7:0]    elem_ff, elem_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] list_head_ff, list_head_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] cnt_ff, cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_index_ff, rsp_index_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   // memories
   logic [LW-1:0] link_mem [NODE_COUNT];
   logic [7:0]    byte_mem [NODE_COUNT];
   logic [LW-1:0] link_rd_ff;
   logic [7:0]    byte_rd_ff;
   logic [IW-1:0] rd_addr;
   logic          link_we, byte_we;
   logic [IW-1:0] wr_addr;
   logic [LW-1:0] link_wdata;

   logic          accept;
   logic [LW+3:0] idx_ext;
   logic          idx_ok;
   logic [LW+3:0] fh_ext;
   logic [IW+3:0] cur_ext;
   logic          walk_fin;

   assign accept  = start && (state_ff == ST_IDLE);
   assign idx_ext = (LW+4)'(req_node_index);
   assign idx_ok  = idx_ext < (LW+4)'(NODE_COUNT);
   assign fh_ext  = (LW+4)'(free_head_ff);
   assign cur_ext = (IW+4)'(cur_ff);
   assign walk_fin = (link_rd_ff >= NULL_LINK) || (cnt_ff == LAST_NODE);

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      cmd_in        = cmd_ff;
      elem_in       = elem_ff;
      free_head_in  = free_head_ff;
      list_head_in  = list_head_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = 4'd0;
      rsp_byte_in   = 8'd0;
      rsp_status_in = cfla_pkg::STAT_OK;
      rsp_last_in   = 1'b1;
      rd_addr       = free_head_ff[IW-1:0];
      link_we       = 1'b0;
      byte_we       = 1'b0;
      wr_addr       = init_cnt_ff;
      link_wdata    = LW'(init_cnt_ff) + LW'(1);

      unique case (state_ff)
         ST_INIT: begin
            // chain entry i to i+1; last entry gets null
            link_we     = 1'b1;
            init_cnt_in = init_cnt_ff + IW'(1);
            if (init_cnt_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_cmd;
               elem_in = req_elem_byte;
               unique case (req_cmd)
                  cfla_pkg::CMD_FREE: begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = req_node_index;
                     if (idx_ok) begin
                        link_we      = 1'b1;
                        wr_addr      = idx_ext[IW-1:0];
                        link_wdata   = free_head_ff;
                        free_head_in = idx_ext[LW-1:0];
                     end else begin
                        rsp_status_in = cfla_pkg::STAT_RANGE;
                     end
                  end
                  cfla_pkg::CMD_DUMP: begin
                     rd_addr = list_head_ff[IW-1:0];
                     if (list_head_ff >= NULL_LINK) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cfla_pkg::STAT_EMPTY;
                     end else begin
                        cur_in   = list_head_ff[IW-1:0];
                        cnt_in   = '0;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     // allocate or insert: pop the free head
                     if (free_head_ff >= NULL_LINK) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cfla_pkg::STAT_NOSPACE;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
               endcase
            end
         end
         ST_POP: begin
            free_head_in = link_rd_ff;
            rsp_valid_in = 1'b1;
            rsp_index_in = fh_ext[3:0];
            if (cmd_ff == cfla_pkg::CMD_INSERT) begin
               link_we      = 1'b1;
               byte_we      = 1'b1;
               wr_addr      = free_head_ff[IW-1:0];
               link_wdata   = list_head_ff;
               list_head_in = free_head_ff;
            end
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = cur_ext[3:0];
            rsp_byte_in  = byte_rd_ff;
            rsp_last_in  = walk_fin;
            rd_addr      = link_rd_ff[IW-1:0];
            if (walk_fin) begin
               state_in = ST_IDLE;
            end else begin
               cur_in = link_rd_ff[IW-1:0];
               cnt_in = cnt_ff + IW'(1);
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         free_head_ff <= '0;
         list_head_ff <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         free_head_ff <= free_head_in;
         list_head_ff <= list_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      elem_ff       <= elem_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[wr_addr] <= elem_ff;
      end
      byte_rd_ff <= byte_mem[rd_addr];
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[design/cfla_checker.sv]
// ----------------------------------------------------------------------------
// cfla_checker
// Port-level checks for the cursor free-list allocator, bound to the top.
// ----------------------------------------------------------------------------
module cfla_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [3:0] rsp_out_index,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   // init pass keeps the block busy right after reset
   a_init_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("not busy after reset");

   // every command either answers next cycle or keeps working
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("command dropped");

   // a dump beat that is not the last is followed by another beat
   a_walk_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("dump walk stalled");

   // no-space and empty results are single, zeroed beats
   a_fail_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cfla_pkg::STAT_NOSPACE ||
                    rsp_status == cfla_pkg::STAT_EMPTY)
      |-> rsp_last && rsp_out_index == 4'd0 && rsp_out_byte == 8'd0)
      else $error("bad failure beat");

endmodule

bind cursor_free_list_allocator cfla_checker u_cfla_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_out_index (rsp_out_index),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);
